[hw/rtl/esp_pkg.sv]
package esp_pkg;

    localparam int CNT_W       = 16;
    localparam int DELTA_W     = 17;
    localparam int DELTA_MAG_W = 16;
    localparam int CPR_W       = 24;
    localparam int RATE_W      = 16;
    localparam int FRAC_W      = 16;
    localparam int PROD_W      = DELTA_MAG_W + RATE_W;
    localparam int RES_W       = 32;
    localparam int ACC_W       = 48;
    localparam int SPD_NUM_W   = PROD_W + FRAC_W;
    localparam int POS_NUM_W   = ACC_W + FRAC_W;

    localparam int REARM       = 20000;
    localparam int CPR_RESET   = 60000;
    localparam int RATE_RESET  = 100;

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 24;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 120;
    localparam int OUT_PAD_W   = OUT_TDATA_W - DELTA_W - 3 * RES_W;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_COUNTS_PER_REV = 1'b0,
        CFG_SAMPLE_RATE    = 1'b1
    } cfg_idx_t;

    // sign and magnitude back to a saturated two's complement word
    function automatic logic signed [RES_W-1:0] sat_mag
    (
        input logic             neg,
        input logic             ovf,
        input logic [RES_W-1:0] mag
    );
        logic signed [RES_W-1:0] res;
        if (ovf || mag[RES_W-1])
        begin
            res = neg ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
        end
        else
        begin
            res = neg ? -$signed(mag) : $signed(mag);
        end
        return res;
    endfunction

endpackage

[hw/rtl/encoder_speed_position_averager.sv]
// Encoder speed and position averager. Each input beat carries one encoder counter sample
// for one motor (counter re-armed at 20000); the block returns one output beat with the count
// delta, the instant speed and the accumulated position in Q16.16, and the mean speed over
// that motor's last WINDOW samples. Samples for a motor at or above MOTORS are dropped with no
// output beat. Speed, position and mean come from bit-serial restoring dividers producing
// one quotient bit per cycle: the 64-step position division runs alongside the 48-step speed
// division, then the mean takes 32 + ceil(log2(WINDOW)) steps. Only one sample is in work at
// a time: the next beat is accepted once the finished item has moved to the output register,
// which waits on tready while that register is full. The previous output beat may be held
// while the next sample is worked on. After reset a clearing sweep zeroes the speed window
// memory, MOTORS * 2**ceil(log2(WINDOW)) entries (16 by default); no sample is taken meanwhile.
// Configuration writes (index 0 counts_per_rev, index 1 sample_rate_hz) take effect at once
// and belong in idle periods only; a counts_per_rev of zero is treated as one.
module encoder_speed_position_averager
    import esp_pkg::*;
#(
    parameter int WINDOW = 8,
    parameter int MOTORS = 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // counter_value[15:0]
    input  logic                   s_axis_tuser,   // motor_select

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // count_delta[16:0], speed_rps[48:17],
                                                   // position_rev[80:49],
                                                   // mean_speed[112:81], zero pad
    output logic                   m_axis_tuser    // motor_index
);

    localparam int PTR_W     = $clog2(WINDOW);
    localparam int MOT_W     = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    localparam int DEPTH     = MOTORS * (2 ** PTR_W);
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int SUM_W     = RES_W + $clog2(WINDOW);
    localparam int AVG_DEN_W = $clog2(WINDOW + 1);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_PREP,
        ST_START,
        ST_DIVIDE,
        ST_WIN_ADD,
        ST_AVG_START,
        ST_AVG,
        ST_FINISH
    } state_t;

    state_t state_reg;

    logic [CPR_W-1:0]  cpr_reg;
    logic [RATE_W-1:0] rate_reg;

    logic [MOT_W-1:0]         sel_reg;
    logic signed [DELTA_W-1:0] delta_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic signed [SUM_W-1:0]  sum_tmp_reg;
    logic                     pos_neg_reg;
    logic                     avg_neg_reg;
    logic signed [RES_W-1:0]  speed_reg;
    logic signed [RES_W-1:0]  pos_reg;
    logic signed [RES_W-1:0]  filt_reg;

    logic signed [ACC_W-1:0] acc_reg [MOTORS];
    logic signed [SUM_W-1:0] sum_reg [MOTORS];
    logic [PTR_W-1:0]        ptr_reg [MOTORS];

    logic                     m_valid_reg;
    logic                     out_sel_reg;
    logic signed [DELTA_W-1:0] out_delta_reg;
    logic signed [RES_W-1:0]  out_speed_reg;
    logic signed [RES_W-1:0]  out_pos_reg;
    logic signed [RES_W-1:0]  out_filt_reg;

    logic                      accept;
    logic                      out_load;
    logic                      sel_ok;
    logic [MOT_W-1:0]          in_sel;
    logic signed [DELTA_W-1:0] in_delta;
    logic [CPR_W-1:0]          cpr_eff;
    logic [DELTA_W-1:0]        delta_neg;
    logic [DELTA_MAG_W-1:0]    delta_mag;
    logic [PROD_W-1:0]         prod_next;
    logic signed [ACC_W:0]     acc_sum;
    logic signed [ACC_W-1:0]   acc_next;
    logic [ACC_W-1:0]          acc_mag;
    logic signed [SUM_W-1:0]   sum_next;
    logic [SUM_W-1:0]          sum_mag;
    logic [PTR_W-1:0]          ptr_cur;
    logic [PTR_W-1:0]          ptr_next;

    logic                    win_clearing;
    logic                    win_rd_en;
    logic                    win_wr_en;
    logic [ADDR_W-1:0]       win_addr;
    logic signed [RES_W-1:0] win_rd_data;

    logic                  div_start;
    logic                  avg_start;
    logic [SPD_NUM_W-1:0]  spd_num;
    logic [POS_NUM_W-1:0]  pos_num;
    logic                  spd_done, pos_done, avg_done;
    logic [RES_W-1:0]      spd_quot, pos_quot, avg_quot;
    logic                  spd_ovf, pos_ovf, avg_ovf;

    // input side
    assign s_axis_tready = (state_reg == ST_IDLE) && !win_clearing;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_sel        = MOT_W'(s_axis_tuser);
    assign sel_ok        = (32'(s_axis_tuser) < 32'(MOTORS));
    assign in_delta      = $signed(DELTA_W'(REARM) - {1'b0, s_axis_tdata[CNT_W-1:0]});

    // output register loads when empty or being drained this cycle
    assign out_load = (state_reg == ST_FINISH) && (!m_valid_reg || m_axis_tready);

    assign cpr_eff = (cpr_reg == '0) ? CPR_W'(1) : cpr_reg;

    // speed numerator magnitude
    assign delta_neg = -delta_reg;
    assign delta_mag = delta_reg[DELTA_W-1] ? delta_neg[DELTA_MAG_W-1:0]
                                            : delta_reg[DELTA_MAG_W-1:0];
    assign prod_next = PROD_W'(delta_mag) * PROD_W'(rate_reg);

    // saturating count accumulator
    assign acc_sum  = (ACC_W+1)'(acc_reg[sel_reg]) + (ACC_W+1)'(delta_reg);
    assign acc_next = (acc_sum[ACC_W] != acc_sum[ACC_W-1])
                    ? (acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}})
                    : acc_sum[ACC_W-1:0];
    assign acc_mag  = acc_reg[sel_reg][ACC_W-1] ? ACC_W'(-acc_reg[sel_reg])
                                                : ACC_W'(acc_reg[sel_reg]);

    assign spd_num = {prod_reg, {FRAC_W{1'b0}}};
    assign pos_num = {acc_mag, {FRAC_W{1'b0}}};

    // window bookkeeping
    assign sum_next = sum_tmp_reg + SUM_W'(speed_reg);
    assign sum_mag  = sum_reg[sel_reg][SUM_W-1] ? SUM_W'(-sum_reg[sel_reg])
                                                : SUM_W'(sum_reg[sel_reg]);
    assign ptr_cur  = (state_reg == ST_IDLE) ? ptr_reg[in_sel] : ptr_reg[sel_reg];
    assign ptr_next = (ptr_reg[sel_reg] == PTR_W'(WINDOW - 1)) ? '0
                                                              : ptr_reg[sel_reg] + PTR_W'(1);

    assign win_rd_en = accept && sel_ok;
    assign win_wr_en = (state_reg == ST_WIN_ADD);
    assign win_addr  = (state_reg == ST_IDLE) ? ADDR_W'({in_sel, ptr_cur})
                                              : ADDR_W'({sel_reg, ptr_cur});

    assign div_start = (state_reg == ST_START);
    assign avg_start = (state_reg == ST_AVG_START);

    esp_window
    #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    )
    u_window
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .clearing (win_clearing),
        .rd_en    (win_rd_en),
        .wr_en    (win_wr_en),
        .addr     (win_addr),
        .wr_data  (speed_reg),
        .rd_data  (win_rd_data)
    );

    esp_serdiv
    #(
        .NUM_W (SPD_NUM_W),
        .DEN_W (CPR_W)
    )
    u_spd_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (spd_num),
        .den   (cpr_eff),
        .done  (spd_done),
        .quot  (spd_quot),
        .ovf   (spd_ovf)
    );

    esp_serdiv
    #(
        .NUM_W (POS_NUM_W),
        .DEN_W (CPR_W)
    )
    u_pos_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (pos_num),
        .den   (cpr_eff),
        .done  (pos_done),
        .quot  (pos_quot),
        .ovf   (pos_ovf)
    );

    esp_serdiv
    #(
        .NUM_W (SUM_W),
        .DEN_W (AVG_DEN_W)
    )
    u_avg_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (avg_start),
        .num   (sum_mag),
        .den   (AVG_DEN_W'(WINDOW)),
        .done  (avg_done),
        .quot  (avg_quot),
        .ovf   (avg_ovf)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpr_reg  <= CPR_W'(CPR_RESET);
            rate_reg <= RATE_W'(RATE_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COUNTS_PER_REV: cpr_reg  <= cfg_data[CPR_W-1:0];
                CFG_SAMPLE_RATE:    rate_reg <= cfg_data[RATE_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_reg       <= '0;
            delta_reg     <= '0;
            prod_reg      <= '0;
            sum_tmp_reg   <= '0;
            pos_neg_reg   <= 1'b0;
            avg_neg_reg   <= 1'b0;
            speed_reg     <= '0;
            pos_reg       <= '0;
            filt_reg      <= '0;
            m_valid_reg   <= 1'b0;
            out_sel_reg   <= 1'b0;
            out_delta_reg <= '0;
            out_speed_reg <= '0;
            out_pos_reg   <= '0;
            out_filt_reg  <= '0;
            for (int m = 0; m < MOTORS; m++)
            begin
                acc_reg[m] <= '0;
                sum_reg[m] <= '0;
                ptr_reg[m] <= '0;
            end
        end
        else
        begin
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && sel_ok)
                    begin
                        sel_reg   <= in_sel;
                        delta_reg <= in_delta;
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    prod_reg         <= prod_next;
                    acc_reg[sel_reg] <= acc_next;
                    sum_tmp_reg      <= sum_reg[sel_reg] - SUM_W'(win_rd_data);
                    state_reg        <= ST_START;
                end
                ST_START:
                begin
                    pos_neg_reg <= acc_reg[sel_reg][ACC_W-1];
                    state_reg   <= ST_DIVIDE;
                end
                ST_DIVIDE:
                begin
                    if (spd_done && pos_done)
                    begin
                        speed_reg <= sat_mag(delta_reg[DELTA_W-1], spd_ovf, spd_quot);
                        pos_reg   <= sat_mag(pos_neg_reg, pos_ovf, pos_quot);
                        state_reg <= ST_WIN_ADD;
                    end
                end
                ST_WIN_ADD:
                begin
                    sum_reg[sel_reg] <= sum_next;
                    ptr_reg[sel_reg] <= ptr_next;
                    state_reg        <= ST_AVG_START;
                end
                ST_AVG_START:
                begin
                    avg_neg_reg <= sum_reg[sel_reg][SUM_W-1];
                    state_reg   <= ST_AVG;
                end
                ST_AVG:
                begin
                    if (avg_done)
                    begin
                        filt_reg  <= sat_mag(avg_neg_reg, avg_ovf, avg_quot);
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_load)
                    begin
                        out_sel_reg   <= sel_reg[0];
                        out_delta_reg <= delta_reg;
                        out_speed_reg <= speed_reg;
                        out_pos_reg   <= pos_reg;
                        out_filt_reg  <= filt_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = out_sel_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_filt_reg, out_pos_reg, out_speed_reg,
                            out_delta_reg};

    a_no_beat_while_clearing : assert property (@(posedge clk) disable iff (!rst_n)
        win_clearing |-> !s_axis_tready)
        else $error("sample taken during window clearing");

    a_dividers_finished : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WIN_ADD) |-> (spd_done && pos_done))
        else $error("window update before divisions finished");

    a_motor_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (32'(sel_reg) < 32'(MOTORS)))
        else $error("item in flight for a motor out of range");

    a_output_from_finish : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_FINISH))
        else $error("output beat raised outside finish");

endmodule

[hw/rtl/esp_serdiv.sv]
module esp_serdiv
    import esp_pkg::*;
#(
    parameter int NUM_W = 48,
    parameter int DEN_W = 24
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [RES_W-1:0] quot,
    output logic             ovf
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [RES_W-1:0] quot_reg, quot_next;
    logic             ovf_reg, ovf_next;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           fits;

    // one quotient bit per cycle, dividend shifted in msb first
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        ovf_next  = ovf_reg;
        if (start)
        begin
            cnt_next  = CNT_W'(NUM_W);
            num_next  = num;
            rem_next  = '0;
            den_next  = den;
            quot_next = '0;
            ovf_next  = 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - CNT_W'(1);
            num_next  = {num_reg[NUM_W-2:0], 1'b0};
            rem_next  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quot_next = {quot_reg[RES_W-2:0], fits};
            // quotient bits above the result width only mark overflow
            ovf_next  = ovf_reg | quot_reg[RES_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
        ovf_reg  <= ovf_next;
    end

    assign done = (cnt_reg == '0);
    assign quot = quot_reg;
    assign ovf  = ovf_reg;

endmodule

[hw/rtl/esp_window.sv]
module esp_window
    import esp_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    output logic                    clearing,
    input  logic                    rd_en,
    input  logic                    wr_en,
    input  logic [ADDR_W-1:0]       addr,
    input  logic signed [RES_W-1:0] wr_data,
    output logic signed [RES_W-1:0] rd_data
);

    localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);

    logic signed [RES_W-1:0] mem [DEPTH];
    logic signed [RES_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]       clr_cnt_reg, clr_cnt_next;
    logic                    clearing_reg, clearing_next;

    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
            if (clr_cnt_reg == LAST)
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clearing_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clearing_reg <= clearing_next;
        end
    end

    // zeroing sweep after reset, one entry a cycle; afterwards writes and registered reads
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign clearing = clearing_reg;
    assign rd_data  = rd_data_reg;

    a_no_access_while_clearing : assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> (!wr_en && !rd_en))
        else $error("window accessed during clearing sweep");

    a_sweep_covers_all : assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clearing_reg) |-> ($past(clr_cnt_reg) == LAST))
        else $error("clearing sweep ended early");

endmodule

[test/encoder_speed_position_averager_tb.sv]
`timescale 1ns / 1ps

module encoder_speed_position_averager_tb
    import esp_pkg::*;
;

    localparam int WINDOW      = 8;
    localparam int MOTORS      = 2;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_BEATS = 250;
    localparam longint ACC_HI  = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint ACC_LO  = -ACC_HI - 1;

    typedef struct {
        logic                      motor;
        logic signed [DELTA_W-1:0] delta;
        logic signed [RES_W-1:0]   speed;
        logic signed [RES_W-1:0]   position;
        logic signed [RES_W-1:0]   mean_speed;
    } motor_reading_t;

    class speed_position_tracker;
        logic [CPR_W-1:0]  counts_per_rev;
        logic [RATE_W-1:0] sample_rate;
        longint            speed_ring [MOTORS][WINDOW];
        longint            ring_sum [MOTORS];
        int unsigned       ring_slot [MOTORS];
        longint            count_total [MOTORS];
        motor_reading_t    pending_readings [$];
        int                errors;
        int                samples;
        int                readings_checked;

        function new();
            counts_per_rev = CPR_W'(CPR_RESET);
            sample_rate    = RATE_W'(RATE_RESET);
            for (int m = 0; m < MOTORS; m++)
            begin
                for (int i = 0; i < WINDOW; i++)
                    speed_ring[m][i] = 0;
                ring_sum[m]    = 0;
                ring_slot[m]   = 0;
                count_total[m] = 0;
            end
            errors           = 0;
            samples          = 0;
            readings_checked = 0;
        endfunction

        function longint clamp_word(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_COUNTS_PER_REV: counts_per_rev = value[CPR_W-1:0];
                CFG_SAMPLE_RATE:    sample_rate    = value[RATE_W-1:0];
                default:            ;
            endcase
        endfunction

        function int pending();
            return pending_readings.size();
        endfunction

        function void note_sample(logic sel, logic [CNT_W-1:0] counter);
            longint         cnt;
            longint         divisor;
            longint         rate;
            longint         delta;
            longint         speed;
            longint         total;
            longint         quot;
            longint         remd;
            longint         pos;
            int unsigned    slot;
            motor_reading_t r;

            cnt     = counter;
            rate    = sample_rate;
            divisor = (counts_per_rev == 0) ? 1 : counts_per_rev;
            delta   = REARM - cnt;
            speed   = clamp_word((delta * rate * (longint'(1) <<< FRAC_W)) / divisor);

            total = count_total[sel] + delta;
            if (total > ACC_HI)
                total = ACC_HI;
            if (total < ACC_LO)
                total = ACC_LO;
            count_total[sel] = total;

            quot = total / divisor;
            remd = total % divisor;
            if (quot > 32767)
                pos = 64'sd2147483647;
            else if (quot < -32768)
                pos = -64'sd2147483648;
            else
                pos = clamp_word(quot * 65536 + (remd * 65536) / divisor);

            slot                  = ring_slot[sel];
            ring_sum[sel]         = ring_sum[sel] - speed_ring[sel][slot] + speed;
            speed_ring[sel][slot] = speed;
            ring_slot[sel]        = (slot + 1) % WINDOW;

            r.motor      = sel;
            r.delta      = delta[DELTA_W-1:0];
            r.speed      = speed[RES_W-1:0];
            r.position   = pos[RES_W-1:0];
            r.mean_speed = RES_W'(clamp_word(ring_sum[sel] / WINDOW));
            pending_readings.push_back(r);
            samples++;
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_reading(logic user, logic [OUT_TDATA_W-1:0] data);
            motor_reading_t r;
            if (pending_readings.size() == 0)
            begin
                errors++;
                $display("%0t: output beat with nothing expected, expected none, actual %h",
                         $time, data);
                return;
            end
            r = pending_readings.pop_front();
            readings_checked++;
            compare_field("motor_index", r.motor, user);
            compare_field("count_delta", r.delta, $signed(data[DELTA_W-1:0]));
            compare_field("speed_rps", r.speed, $signed(data[DELTA_W +: RES_W]));
            compare_field("position_rev", r.position, $signed(data[DELTA_W + RES_W +: RES_W]));
            compare_field("mean_speed", r.mean_speed,
                          $signed(data[DELTA_W + 2 * RES_W +: RES_W]));
            compare_field("pad", 0, data[OUT_TDATA_W-1 -: OUT_PAD_W]);
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    cfg_idx_t               cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    int src_idle_pct;
    int sink_idle_pct;
    int settings_used;
    int quiet_cycles;

    speed_position_tracker sb = new();

    encoder_speed_position_averager #(
        .WINDOW (WINDOW),
        .MOTORS (MOTORS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
        clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result side: random back-pressure and checking
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_reading(m_axis_tuser, m_axis_tdata);
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // cycles without any beat on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, sb.pending());
            $display("encoder_speed_position_averager_tb: done, errors");
            $finish;
        end
    end

    task automatic send_sample(input logic sel, input logic [CNT_W-1:0] counter);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= counter;
        s_axis_tuser  <= sel;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_sample(sel, counter);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] cpr_word,
                                  input logic [CFG_DATA_W-1:0] rate_word);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_COUNTS_PER_REV;
        cfg_data  <= cpr_word;
        @(posedge clk);
        sb.set_reg(CFG_COUNTS_PER_REV, cpr_word);
        cfg_index <= CFG_SAMPLE_RATE;
        cfg_data  <= rate_word;
        @(posedge clk);
        sb.set_reg(CFG_SAMPLE_RATE, rate_word);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] cpr_word;
        logic [CFG_DATA_W-1:0] rate_word;
        logic [CNT_W-1:0]      counter;
        int                    pick;

        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_COUNTS_PER_REV;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        src_idle_pct  = 22;
        sink_idle_pct = 46;
        settings_used = 1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings, window ramp and delta extremes
        send_sample(1'b0, 16'd20000);
        send_sample(1'b0, 16'd0);
        send_sample(1'b0, 16'd65535);
        send_sample(1'b0, 16'd19999);
        send_sample(1'b0, 16'd20001);
        send_sample(1'b1, 16'd0);
        send_sample(1'b1, 16'd65535);
        send_sample(1'b0, 16'd0);
        send_sample(1'b1, 16'd20000);
        send_sample(1'b0, 16'd0);
        send_sample(1'b0, 16'd0);

        // zero counts per rev, fastest rate: speed saturates
        drain_results();
        apply_settings(24'd0, 24'd65535);
        send_sample(1'b0, 16'd0);
        send_sample(1'b0, 16'd65535);
        send_sample(1'b1, 16'd10000);
        send_sample(1'b1, 16'd20000);

        // zero sample rate, largest counts per rev
        drain_results();
        apply_settings(24'hFFFFFF, 24'd0);
        send_sample(1'b0, 16'd0);
        send_sample(1'b1, 16'd65535);
        send_sample(1'b0, 16'd30000);

        // one count per rev: position saturates
        drain_results();
        apply_settings(24'd1, 24'd1);
        send_sample(1'b0, 16'd0);
        send_sample(1'b1, 16'd65535);
        send_sample(1'b1, 16'd65535);

        for (int phase = 0; phase < 8; phase++)
        begin
            drain_results();
            case (phase)
                0:       begin cpr_word  = CFG_DATA_W'(CPR_RESET);
                               rate_word = CFG_DATA_W'(RATE_RESET);             end
                1:       begin cpr_word = 24'd1;        rate_word = 24'd65535;  end
                2:       begin cpr_word = 24'hFFFFFF;   rate_word = 24'd1;      end
                3:       begin cpr_word = CFG_DATA_W'($urandom_range(4096, 1));
                               rate_word = {8'($urandom), 16'($urandom)};       end
                4:       begin cpr_word = 24'($urandom);
                               rate_word = {8'($urandom), 16'($urandom)};       end
                5:       begin cpr_word = 24'd0;
                               rate_word = CFG_DATA_W'($urandom_range(65535));  end
                6:       begin cpr_word = 24'($urandom);
                               rate_word = CFG_DATA_W'($urandom_range(65535));  end
                default: begin cpr_word = 24'd4096;     rate_word = 24'd1000;   end
            endcase
            apply_settings(cpr_word, rate_word);
            if (phase < 3)
            begin
                src_idle_pct  = 22;
                sink_idle_pct = 46;
            end
            else if (phase < 6)
            begin
                src_idle_pct  = 46;
                sink_idle_pct = 22;
            end
            else
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end

            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                pick = $urandom_range(99);
                // mostly plausible motion around the re-arm value
                if (pick < 70)
                    counter = 16'($urandom_range(23000, 17000));
                else if (pick < 85)
                    counter = 16'($urandom);
                else if (pick < 92)
                    counter = $urandom_range(1) ? 16'($urandom_range(15))
                                                : 16'($urandom_range(65535, 65520));
                else
                    counter = 16'(REARM);
                send_sample(1'($urandom), counter);
            end
        end

        drain_results();
        repeat (150) @(posedge clk);
        if (sb.pending() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d results never arrived", $time, sb.pending());
        end
        $display("%0d encoder samples over %0d register settings, %0d output beats checked",
                 sb.samples, settings_used, sb.readings_checked);
        $display("covered zero and extreme scaling, saturation, both motors and three stall mixes");
        if (sb.errors == 0)
            $display("encoder_speed_position_averager_tb: done, clean");
        else
            $display("encoder_speed_position_averager_tb: done, errors");
        $finish;
    end

endmodule
